[rtl/ghash_accumulator_macros.svh]
// ----------------------------------------------------------------------------
// GHASH accumulator assertion macros
// Shared concurrent-assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef GHASH_ACCUMULATOR_MACROS_SVH
`define GHASH_ACCUMULATOR_MACROS_SVH

// Same-cycle implication.
`define GHACC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ghash_accumulator: assertion failed");

// Next-cycle implication.
`define GHACC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ghash_accumulator: assertion failed");

`endif

[rtl/ghacc_pkg.sv]
// ----------------------------------------------------------------------------
// GHASH accumulator package
// Shared widths, queue sizing, register indexes and the GF(2^128) multiply.
// ----------------------------------------------------------------------------
package ghacc_pkg;

  localparam int HALF_W     = 64;
  localparam int BLOCK_W    = 2 * HALF_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W  = 1;

  typedef logic [HALF_W-1:0]  half_t;
  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [QUEUE_AW-1:0] qptr_t;
  typedef logic [QUEUE_AW:0]   qcount_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam qcount_t  QUEUE_FULL   = qcount_t'(QUEUE_DEPTH);
  localparam qptr_t    QPTR_LAST    = qptr_t'(QUEUE_DEPTH - 1);
  localparam cfg_idx_t CFG_KEY_HIGH = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_KEY_LOW  = cfg_idx_t'(1);

  // Queued item: the block in GCM bit order plus its end-of-message flag.
  typedef struct packed {
    block_t block;
    logic   last;
  } item_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic    valid;
    qcount_t count;
  } front_stat_t;

  // GF(2^128) product in GCM bit order (bit 127 of the vector is x^0).
  // Full carry-less product, then two folds with x^128 = x^7 + x^2 + x + 1.
  function automatic block_t gf128_mul(input block_t x, input block_t y);
    block_t          a;
    block_t          b;
    logic [254:0]    p;
    logic [133:0]    r;
    logic [5:0]      t;
    block_t          z;
    block_t          res;
    for (int i = 0; i < BLOCK_W; i++) begin
      a[i] = x[BLOCK_W-1-i];
      b[i] = y[BLOCK_W-1-i];
    end
    for (int k = 0; k < 255; k++) begin
      p[k] = 1'b0;
      for (int i = 0; i < BLOCK_W; i++) begin
        if ((k >= i) && ((k - i) < BLOCK_W)) begin
          p[k] = p[k] ^ (a[i] & b[k-i]);
        end
      end
    end
    r = {6'b0, p[127:0]} ^ {7'b0, p[254:128]} ^ {6'b0, p[254:128], 1'b0}
      ^ {5'b0, p[254:128], 2'b0} ^ {p[254:128], 7'b0};
    t = r[133:128];
    z = r[127:0] ^ {122'b0, t} ^ {121'b0, t, 1'b0} ^ {120'b0, t, 2'b0}
      ^ {115'b0, t, 7'b0};
    for (int i = 0; i < BLOCK_W; i++) begin
      res[i] = z[BLOCK_W-1-i];
    end
    return res;
  endfunction

endpackage

[rtl/ghacc_in_if.sv]
// ----------------------------------------------------------------------------
// GHASH accumulator input channel
// Valid/ready channel carrying one 128-bit block and its last flag.
// ----------------------------------------------------------------------------
interface ghacc_in_if;
  logic             valid;
  logic             ready;
  ghacc_pkg::half_t block_high;
  ghacc_pkg::half_t block_low;
  logic             last_block;

  modport source (output valid, output block_high, output block_low,
                  output last_block, input ready);
  modport sink   (input valid, input block_high, input block_low,
                  input last_block, output ready);
endinterface

[rtl/ghacc_out_if.sv]
// ----------------------------------------------------------------------------
// GHASH accumulator result channel
// Valid/ready channel carrying one 128-bit hash.
// ----------------------------------------------------------------------------
interface ghacc_out_if;
  logic             valid;
  logic             ready;
  ghacc_pkg::half_t hash_high;
  ghacc_pkg::half_t hash_low;

  modport source (output valid, output hash_high, output hash_low, input ready);
  modport sink   (input valid, input hash_high, input hash_low, output ready);
endinterface

[rtl/ghacc_front.sv]
// ----------------------------------------------------------------------------
// GHASH accumulator front end
// Accepts input items, packs them and holds them in a short FIFO.
// ----------------------------------------------------------------------------
module ghacc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  ghacc_in_if.sink               in_ch,
  input  logic                   q_pop,
  output ghacc_pkg::item_t       q_item,
  output ghacc_pkg::front_stat_t q_stat
);

  ghacc_pkg::item_t   mem_r [ghacc_pkg::QUEUE_DEPTH];
  ghacc_pkg::qptr_t   wr_ptr_r, wr_ptr_nxt;
  ghacc_pkg::qptr_t   rd_ptr_r, rd_ptr_nxt;
  ghacc_pkg::qcount_t count_r, count_nxt;
  ghacc_pkg::item_t   in_item;
  logic               push;

  assign in_ch.ready = (count_r != ghacc_pkg::QUEUE_FULL);
  assign push        = in_ch.valid && in_ch.ready;

  assign in_item.block = {in_ch.block_high, in_ch.block_low};
  assign in_item.last  = in_ch.last_block;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ghacc_pkg::QPTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ghacc_pkg::QPTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  assign q_item       = mem_r[rd_ptr_r];
  assign q_stat.valid = (count_r != '0);
  assign q_stat.count = count_r;

endmodule

[rtl/ghacc_back.sv]
// ----------------------------------------------------------------------------
// GHASH accumulator back end
// Folds queued blocks into the accumulator and drives the hash output register.
// ----------------------------------------------------------------------------
module ghacc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ghacc_pkg::block_t      hash_key,
  input  ghacc_pkg::item_t       q_item,
  input  ghacc_pkg::front_stat_t q_stat,
  output logic                   q_pop,
  ghacc_out_if.source            out_ch
);

  ghacc_pkg::block_t acc_r, acc_nxt;
  ghacc_pkg::block_t hash_r, hash_nxt;
  logic              out_valid_r, out_valid_nxt;
  ghacc_pkg::block_t prod;

  // A non-last block never needs the output slot; a last one needs it free.
  assign q_pop = q_stat.valid && (!q_item.last || !out_valid_r || out_ch.ready);
  assign prod  = ghacc_pkg::gf128_mul(acc_r ^ q_item.block, hash_key);

  always_comb begin
    acc_nxt       = acc_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (q_pop) begin
      if (q_item.last) begin
        acc_nxt       = '0;
        hash_nxt      = prod;
        out_valid_nxt = 1'b1;
      end else begin
        acc_nxt = prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hash_high = hash_r[ghacc_pkg::BLOCK_W-1:ghacc_pkg::HALF_W];
  assign out_ch.hash_low  = hash_r[ghacc_pkg::HALF_W-1:0];

endmodule

[rtl/ghash_accumulator.sv]
// ----------------------------------------------------------------------------
// GHASH accumulator
// GCM GHASH engine: one 128-bit block per cycle, output stalls aside, folded into a running hash.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready; one item is a 128-bit block (block_high first) plus
//            last_block. Padding and the length block come from upstream.
//   out_ch : valid/ready; one item (hash_high, hash_low) per message, issued
//            after the block flagged last_block.
//   cfg_*  : write port for the hash key H; index 0 = high half, 1 = low half.
//            Write only while idle (queue drained, no hash pending).
// Path: a last block is written into the FIFO; once it is at the FIFO head and
//   the output slot is free, its hash lands in the hash reg and shows on out_ch.
// Throughput: one block per cycle, unless a last block waits at the FIFO head
//   for a held output; the combinational multiply closes the accumulator feedback loop.
// Reset: key registers and accumulator clear to zero, FIFO empties, no result.
// Output stall: the hash stays in the output register; non-last blocks keep
//   folding in behind it, and a following last block waits at the FIFO head.
//   in_ch.ready drops only when the 4-entry FIFO is full.
// ----------------------------------------------------------------------------
`include "ghash_accumulator_macros.svh"

module ghash_accumulator (
  input  logic                clk,
  input  logic                rst_n,
  ghacc_in_if.sink            in_ch,
  ghacc_out_if.source         out_ch,
  input  logic                cfg_we,
  input  ghacc_pkg::cfg_idx_t cfg_index,
  input  ghacc_pkg::half_t    cfg_data
);

  // Hash key H, held as two halves.
  ghacc_pkg::half_t key_high_r, key_high_nxt;
  ghacc_pkg::half_t key_low_r, key_low_nxt;

  // Front/back hand-off.
  ghacc_pkg::item_t       q_item;
  ghacc_pkg::front_stat_t q_stat;
  logic                   q_pop;

  always_comb begin
    key_high_nxt = key_high_r;
    key_low_nxt  = key_low_r;
    if (cfg_we) begin
      case (cfg_index)
        ghacc_pkg::CFG_KEY_HIGH: key_high_nxt = cfg_data;
        ghacc_pkg::CFG_KEY_LOW:  key_low_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else begin
      key_high_r <= key_high_nxt;
      key_low_r  <= key_low_nxt;
    end
  end

  // Front end: accepts and queues blocks.
  ghacc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_pop  (q_pop),
    .q_item (q_item),
    .q_stat (q_stat)
  );

  // Back end: multiply-accumulate and hash output register.
  ghacc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .hash_key ({key_high_r, key_low_r}),
    .q_item   (q_item),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

  // A last block leaves the FIFO only when the output slot can take its hash.
  `GHACC_ASSERT_IMPL(a_last_pop_slot, clk, rst_n, q_pop && q_item.last, !out_ch.valid || out_ch.ready)

  // Folding a last block always presents a hash next cycle.
  `GHACC_ASSERT_NEXT(a_last_emits, clk, rst_n, q_pop && q_item.last, out_ch.valid)

  // An accepted item with no pop grows the FIFO by exactly one.
  `GHACC_ASSERT_NEXT(a_fifo_grow, clk, rst_n, in_ch.valid && in_ch.ready && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1)

endmodule

[dv/tb_ghash_accumulator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GHASH accumulator testbench
// Drives 128-bit blocks with random idle and stall bursts, tracks the running
// GF(2^128) hash under the current key, and compares every hash the block
// emits against the tracked value in order.
// ----------------------------------------------------------------------------

module tb_ghash_accumulator;

  // Reduction constant in GCM bit order: x^128 = x^7 + x^2 + x + 1, folded
  // in at the top byte after a right shift drops bit 0.
  localparam ghacc_pkg::block_t GF_FOLD = {8'hE1, 120'b0};
  // Multiplicative identity in GCM bit order (x^0 sits at bit 127).
  localparam ghacc_pkg::block_t GF_ONE  = {1'b1, 127'b0};
  localparam int ITEMS_RANDOM  = 2000;
  localparam int CALM_TAIL     = 300;    // final stretch with no idling
  localparam int DRAIN_CYCLES  = 12;     // 4-deep FIFO plus hash register, with margin
  localparam int CYCLE_LIMIT   = 400000;

  // --------------------------------------------------------------------------
  // Hash tracker: own copy of key and running sum, queue of hashes owed.
  // --------------------------------------------------------------------------
  class ghash_tracker;
    ghacc_pkg::block_t hash_key    = '0;
    ghacc_pkg::block_t running_sum = '0;
    ghacc_pkg::block_t pending_hashes[$];
    int                mismatches  = 0;

    function void set_key_half(ghacc_pkg::cfg_idx_t idx, ghacc_pkg::half_t value);
      if (idx == ghacc_pkg::CFG_KEY_HIGH) hash_key[127:64] = value;
      else                                hash_key[63:0]   = value;
    endfunction

    // Shift-and-add multiply by H, bit 127 of x first.
    function ghacc_pkg::block_t mul_by_key(ghacc_pkg::block_t x);
      ghacc_pkg::block_t prod;
      ghacc_pkg::block_t v;
      prod = '0;
      v    = hash_key;
      for (int i = ghacc_pkg::BLOCK_W - 1; i >= 0; i--) begin
        if (x[i]) prod ^= v;
        v = v[0] ? ((v >> 1) ^ GF_FOLD) : (v >> 1);
      end
      return prod;
    endfunction

    function void absorb_block(ghacc_pkg::half_t hi, ghacc_pkg::half_t lo, logic last);
      ghacc_pkg::block_t prod;
      prod = mul_by_key(running_sum ^ {hi, lo});
      if (last) begin
        pending_hashes.push_back(prod);
        running_sum = '0;
      end else begin
        running_sum = prod;
      end
    endfunction

    function void check_hash(ghacc_pkg::half_t hi, ghacc_pkg::half_t lo);
      ghacc_pkg::block_t want;
      if (pending_hashes.size() == 0) begin
        $display("%0t: hash with none owed: expected none, actual %h_%h", $time, hi, lo);
        mismatches++;
        return;
      end
      want = pending_hashes.pop_front();
      if (want[127:64] !== hi) begin
        $display("%0t: hash_high expected %h actual %h", $time, want[127:64], hi);
        mismatches++;
      end
      if (want[63:0] !== lo) begin
        $display("%0t: hash_low expected %h actual %h", $time, want[63:0], lo);
        mismatches++;
      end
    endfunction

    function int owed();
      return pending_hashes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // --------------------------------------------------------------------------
  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we;
  ghacc_pkg::cfg_idx_t cfg_index;
  ghacc_pkg::half_t    cfg_data;

  ghacc_in_if  in_ch ();
  ghacc_out_if out_ch ();

  ghash_accumulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ghash_tracker sb;
  int  items_sent     = 0;
  int  cycle_count    = 0;
  bit  calm           = 1'b0;  // set for the tail: no gaps, no stalls
  int  in_gap_pct     = 0;     // chance (percent) of an idle burst before an item
  int  out_stall_pct  = 0;     // chance (percent) per cycle of a ready-low burst

  // --------------------------------------------------------------------------
  // Monitor and watchdog. Outputs are checked before the input of the same
  // edge is absorbed; a hash never leaves in the cycle its last block enters,
  // so this order is safe and independent of process scheduling.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_hash(out_ch.hash_high, out_ch.hash_low);
      if (in_ch.valid && in_ch.ready)
        sb.absorb_block(in_ch.block_high, in_ch.block_low, in_ch.last_block);
    end
  end

  // Result-side backpressure: ready-low bursts of random length.
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!calm && ($urandom_range(0, 99) < out_stall_pct)) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Random half with a bias toward all-zero, all-one and single-bit values.
  function automatic ghacc_pkg::half_t rand_half();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return ghacc_pkg::half_t'(1) << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One item on in_ch, optionally preceded by an idle burst.
  task automatic send_block(ghacc_pkg::half_t hi, ghacc_pkg::half_t lo, logic last);
    int gap;
    gap = 0;
    if (!calm && ($urandom_range(0, 99) < in_gap_pct)) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.block_high = hi;
    in_ch.block_low  = lo;
    in_ch.last_block = last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (items_sent >= ITEMS_RANDOM - CALM_TAIL + 25) calm = 1'b1;
  endtask

  // Message of n blocks with random content; the last one closes it when asked.
  task automatic send_message(int n, bit close_it);
    for (int i = 0; i < n; i++)
      send_block(rand_half(), rand_half(), close_it && (i == n - 1));
  endtask

  // Sender goes quiet until every owed hash is out, then lets the FIFO and
  // multiplier drain any non-last blocks still in flight.
  task automatic drain_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.owed() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write; only called after drain_idle.
  task automatic write_reg(ghacc_pkg::cfg_idx_t idx, ghacc_pkg::half_t value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.set_key_half(idx, value);
  endtask

  task automatic write_key(ghacc_pkg::block_t key);
    write_reg(ghacc_pkg::CFG_KEY_HIGH, key[127:64]);
    write_reg(ghacc_pkg::CFG_KEY_LOW,  key[63:0]);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    ghacc_pkg::block_t key;
    int                n_msgs;
    int                len;

    sb = new();
    in_ch.valid      = 1'b0;
    in_ch.block_high = '0;
    in_ch.block_low  = '0;
    in_ch.last_block = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = ghacc_pkg::CFG_KEY_HIGH;
    cfg_data         = '0;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // ---- Directed part ----
    // Zero key out of reset: every hash is zero.
    send_block('1, '1, 1'b1);
    send_message(2, 1'b1);

    // Single-block messages on a random key: extremes of the block fields.
    drain_idle();
    write_key({$urandom, $urandom, $urandom, $urandom});
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b1);
    send_block('0, ghacc_pkg::half_t'(1), 1'b1);
    send_block({1'b1, 63'b0}, '0, 1'b1);

    // Multi-block message.
    send_message(3, 1'b1);

    // Key change mid-message: earlier blocks keep the old key's products.
    send_message(2, 1'b0);
    drain_idle();
    write_key('1);
    send_block(rand_half(), rand_half(), 1'b1);

    // Identity key: single-block hash equals the block.
    drain_idle();
    write_key(GF_ONE);
    send_block(rand_half(), rand_half(), 1'b1);
    send_message(2, 1'b1);

    // Only the low half changes; high half of H stays.
    drain_idle();
    write_reg(ghacc_pkg::CFG_KEY_LOW, rand_half());
    send_message(3, 1'b1);

    // Back to a zero key with an open message carried across.
    send_message(1, 1'b0);
    drain_idle();
    write_key('0);
    send_message(2, 1'b1);

    // ---- Random part: phases of messages under one key setting ----
    while (items_sent < ITEMS_RANDOM + 25) begin
      // Key setting for this phase; a message may still be open across it.
      // The calm tail keeps the current key and streams without pauses.
      if (!calm) begin
        drain_idle();
        case ($urandom_range(0, 5))
          0:       key = '0;
          1:       key = '1;
          2:       key = GF_ONE;
          default: key = {$urandom, $urandom, $urandom, $urandom};
        endcase
        case ($urandom_range(0, 3))
          0:       write_reg(ghacc_pkg::CFG_KEY_HIGH, key[127:64]);
          1:       write_reg(ghacc_pkg::CFG_KEY_LOW, key[63:0]);
          default: write_key(key);
        endcase
      end

      // Idle mix for this phase, including stretches with none at all.
      case ($urandom_range(0, 3))
        0:       in_gap_pct = 0;
        1:       in_gap_pct = 5;
        2:       in_gap_pct = 20;
        default: in_gap_pct = 50;
      endcase
      case ($urandom_range(0, 3))
        0:       out_stall_pct = 0;
        1:       out_stall_pct = 3;
        2:       out_stall_pct = 10;
        default: out_stall_pct = 30;
      endcase

      n_msgs = $urandom_range(3, 15);
      for (int m = 0; m < n_msgs; m++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
        // The phase's final message is sometimes left open for the next key.
        send_message(len, !((m == n_msgs - 1) && ($urandom_range(0, 3) == 0)));
      end
    end
    // Close whatever message is still open.
    send_block(rand_half(), rand_half(), 1'b1);

    // ---- Wind-down ----
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
